// ===== rtl/mrw_pkg.sv =====
// Package for the Miller-Rabin witness round core.
// Holds the word type passed from the front end to the back end; no dependencies.
package mrw_pkg;
   localparam int WordBits = 63;

   typedef struct packed {
      logic [WordBits-1:0] candidate;
      logic [WordBits-1:0] witness_base;
   } job_type;
endpackage

// ===== rtl/mrw_front.sv =====
// Front end: takes request words and holds them in a two-entry queue.
// Depends on mrw_pkg.
module mrw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mrw_pkg::job_type req_job,
   output logic             job_valid,
   input  logic             job_ready,
   output mrw_pkg::job_type job_out
);
   import mrw_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_ready = (count_ff != 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job_out   = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= req_job;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("push lost");
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("pop lost");
endmodule

// ===== rtl/mrw_back.sv =====
// Back end: runs one witness round with a bit-serial modular multiplier.
// Depends on mrw_pkg.
module mrw_back #(
   parameter int OPERAND_BITS = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  mrw_pkg::job_type job_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_verdict
);
   import mrw_pkg::*;

   localparam int W  = OPERAND_BITS;
   localparam int CW = $clog2(W + 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_SHIFT = 4'd2,
      S_POW = 4'd3, S_MUL = 4'd4, S_CHK = 4'd5, S_SQR = 4'd6, S_DONE = 4'd7;
   // What the multiplier result feeds.
   localparam logic [1:0] M_ACC = 2'd0, M_SQ = 2'd1, M_X = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [W-1:0]  n_ff, n_in, sq_ff, sq_in, acc_ff, acc_in, e_ff, e_in;
   logic [CW-1:0] s_ff, s_in, j_ff, j_in, bit_ff, bit_in;
   logic [W-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [W:0]    r_ff, r_in, t1, t2, t3;
   logic [1:0]    mdst_ff, mdst_in;
   logic          v_ff, v_in, rv_ff, rv_in;
   logic [W-1:0]  nm1;

   assign job_ready   = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid   = rv_ff;
   assign rsp_verdict = v_ff;
   assign nm1         = n_ff - 1'b1;

   // One multiplier step: double, reduce, conditionally add, reduce.
   always_comb begin
      t1 = {r_ff[W-1:0], 1'b0};
      if (t1 >= {1'b0, n_ff}) t1 = t1 - {1'b0, n_ff};
      t2 = t1 + {1'b0, ma_ff};
      if (t2 >= {1'b0, n_ff}) t2 = t2 - {1'b0, n_ff};
      t3 = mb_ff[bit_ff[$clog2(W)-1:0]] ? t2 : t1;
   end

   always_comb begin
      state_in = state_ff; n_in = n_ff; sq_in = sq_ff; acc_in = acc_ff;
      e_in = e_ff; s_in = s_ff; j_in = j_ff; bit_in = bit_ff;
      ma_in = ma_ff; mb_in = mb_ff; r_in = r_ff; mdst_in = mdst_ff;
      v_in = v_ff; rv_in = rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && job_ready) begin
               n_in  = job_in.candidate[W-1:0];
               sq_in = job_in.witness_base[W-1:0];
               state_in = S_RED;
            end
         end
         // Base mod n by repeated compare-subtract is too slow; use the
         // multiplier: base * 1 mod n with base fed bit by bit.
         S_RED: begin
            if (n_ff == {{(W-2){1'b0}}, 2'd2}) begin
               v_in = 1'b1; state_in = S_DONE;
            end else if (n_ff < {{(W-2){1'b0}}, 2'd2} || !n_ff[0]) begin
               v_in = 1'b0; state_in = S_DONE;
            end else begin
               ma_in = {{(W-1){1'b0}}, 1'b1}; mb_in = sq_ff;
               r_in = '0; bit_in = CW'(W - 1); mdst_in = M_SQ;
               e_in = nm1; s_in = '0; acc_in = {{(W-1){1'b0}}, 1'b1};
               state_in = S_MUL;
            end
         end
         S_SHIFT: begin
            if (sq_ff == '0) begin
               v_in = 1'b1; state_in = S_DONE;
            end else if (!e_ff[0]) begin
               e_in = e_ff >> 1; s_in = s_ff + 1'b1;
            end else state_in = S_POW;
         end
         S_POW: begin
            r_in = '0; bit_in = CW'(W - 1);
            if (e_ff == '0) state_in = S_CHK;
            else if (e_ff[0]) begin
               ma_in = acc_ff; mb_in = sq_ff; mdst_in = M_ACC; state_in = S_MUL;
            end else begin
               ma_in = sq_ff; mb_in = sq_ff; mdst_in = M_SQ; state_in = S_MUL;
            end
         end
         S_MUL: begin
            r_in = t3;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               unique case (mdst_ff)
                  M_ACC: begin
                     acc_in = t3[W-1:0]; ma_in = sq_ff; mb_in = sq_ff;
                     r_in = '0; bit_in = CW'(W - 1); mdst_in = M_SQ;
                  end
                  M_SQ: begin
                     sq_in = t3[W-1:0];
                     if (s_ff == '0 && e_ff == nm1) state_in = S_SHIFT;
                     else begin
                        e_in = e_ff >> 1; state_in = S_POW;
                     end
                  end
                  M_X: begin
                     acc_in = t3[W-1:0]; state_in = S_SQR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHK: begin
            if (acc_ff == {{(W-1){1'b0}}, 1'b1} || acc_ff == nm1) begin
               v_in = 1'b1; state_in = S_DONE;
            end else begin
               j_in = {{(CW-1){1'b0}}, 1'b1}; state_in = S_SQR;
               v_in = 1'b0;
            end
         end
         S_SQR: begin
            if (j_ff != {{(CW-1){1'b0}}, 1'b1} || mdst_ff == M_X) begin
               if (acc_ff == {{(W-1){1'b0}}, 1'b1}) begin
                  v_in = 1'b0; state_in = S_DONE;
               end else if (acc_ff == nm1) begin
                  v_in = 1'b1; state_in = S_DONE;
               end
            end
            if (state_in == S_SQR) begin
               if (j_ff >= s_ff) begin
                  v_in = 1'b0; state_in = S_DONE;
               end else begin
                  ma_in = acc_ff; mb_in = acc_ff; r_in = '0;
                  bit_in = CW'(W - 1); mdst_in = M_X; j_in = j_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         mdst_ff  <= M_ACC;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         mdst_ff  <= mdst_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff <= n_in; sq_ff <= sq_in; acc_ff <= acc_in; e_ff <= e_in;
      s_ff <= s_in; j_ff <= j_in; bit_ff <= bit_in; ma_ff <= ma_in;
      mb_ff <= mb_in; r_ff <= r_in; v_ff <= v_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_ready) |=> (rv_ff && $stable(v_ff)))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (r_ff < {1'b0, n_ff}))
      else $error("partial product not reduced");
   assert property (@(posedge clock) disable iff (reset)
      job_ready |-> (state_ff == S_IDLE))
      else $error("job taken while busy");
endmodule

// ===== rtl/miller_rabin_witness_round_core.sv =====
// Top level of the Miller-Rabin witness round core.
// Depends on mrw_pkg, mrw_front and mrw_back.
//
//   Channel | Handshake              | Words
//   req     | req_valid / req_ready  | req_candidate, req_witness_base
//   rsp     | rsp_valid / rsp_ready  | rsp_verdict
//
// A round is a chain of modular products, each one bit-serial multiplier
// pass over OPERAND_BITS operand bits, with a setup state per exponent bit
// or squaring. A full round uses up to about 2*OPERAND_BITS products;
// trivial candidates skip the multiplier. Reset clears control state
// only. A two-word queue lets request words arrive while a round runs;
// a stalled result holds the back end.
module miller_rabin_witness_round_core #(
   parameter int OPERAND_BITS = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mrw_pkg::WordBits-1:0]   req_candidate,
   input  logic [mrw_pkg::WordBits-1:0]   req_witness_base,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_verdict
);
   import mrw_pkg::*;

   job_type req_job, job;
   logic    job_valid, job_ready;

   // Keep only the operand bits in use.
   always_comb begin
      req_job = '0;
      req_job.candidate[OPERAND_BITS-1:0]    = req_candidate[OPERAND_BITS-1:0];
      req_job.witness_base[OPERAND_BITS-1:0] = req_witness_base[OPERAND_BITS-1:0];
   end

   mrw_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_job,
      .job_valid, .job_ready, .job_out(job)
   );

   mrw_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_in(job),
      .rsp_valid, .rsp_ready, .rsp_verdict
   );
endmodule

// ===== test/miller_rabin_witness_round_core_tb.sv =====
// Testbench for miller_rabin_witness_round_core: drives candidate/base words and
// checks each verdict against an in-bench Miller-Rabin predictor. Depends on mrw_pkg.
module miller_rabin_witness_round_core_tb;
   import mrw_pkg::*;

   localparam int WatchdogLimit = 400000;
   localparam int DrainCycles   = 200;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [WordBits-1:0] req_candidate = '0;
   logic [WordBits-1:0] req_witness_base = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_verdict;

   bit   expected_verdicts[$];
   int   errors = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   unsigned stall_cycle = 0;

   miller_rabin_witness_round_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_candidate(req_candidate), .req_witness_base(req_witness_base),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Exact modular product by shift and add; operands are below n < 2^63.
   function automatic bit [63:0] mul_mod(bit [63:0] a, bit [63:0] b, bit [63:0] n);
      bit [63:0] r;
      r = '0;
      for (int i = WordBits - 1; i >= 0; i--) begin
         r = r + r;
         if (r >= n) r -= n;
         if (b[i]) begin
            r = r + a;
            if (r >= n) r -= n;
         end
      end
      return r;
   endfunction

   // One witness round: verdict 1 means probable prime for this base.
   function automatic bit round_verdict(bit [WordBits-1:0] cand, bit [WordBits-1:0] base);
      bit [63:0] n, b, nm1, d, x, acc, sq;
      int s;
      n = 64'(cand);
      b = 64'(base);
      if (n == 2) return 1'b1;
      if (n < 2 || !n[0]) return 1'b0;
      nm1 = n - 1;
      b = b % n;
      if (b == 0) return 1'b1;
      d = nm1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      acc = 64'd1;
      sq = b;
      while (d != 0) begin
         if (d[0]) acc = mul_mod(acc, sq, n);
         sq = mul_mod(sq, sq, n);
         d = d >> 1;
      end
      x = acc;
      if (x == 1 || x == nm1) return 1'b1;
      for (int j = 1; j < s; j++) begin
         x = mul_mod(x, x, n);
         if (x == 1) return 1'b0;
         if (x == nm1) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit [WordBits-1:0] rand_word();
      return WordBits'({$urandom, $urandom});
   endfunction

   // Append one expected verdict to the scoreboard queue.
   task automatic queue_verdict(bit verdict);
      expected_verdicts = {expected_verdicts, verdict};
   endtask

   // Send one word; the sender runs in bursts and idles between them.
   task automatic send_word(bit [WordBits-1:0] cand, bit [WordBits-1:0] base);
      req_valid <= 1'b1;
      req_candidate <= cand;
      req_witness_base <= base;
      do @(posedge clock); while (!req_ready);
      queue_verdict(round_verdict(cand, base));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 5);
      end
   endtask

   // Hold the sender off until every expected verdict has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   task automatic test_trivial_cases();
      send_word(63'd2, 63'd5);
      send_word(63'd0, 63'd3);
      send_word(63'd1, 63'd0);
      send_word(63'd4, 63'd2);
      send_word({62'h0, 1'b0} | 63'h7FFF_FFFF_FFFF_FFFE, 63'd3);
      send_word(63'd3, 63'd2);
   endtask

   task automatic test_base_edges();
      send_word(63'd97, 63'd0);
      send_word(63'd97, 63'd97);
      send_word(63'd97, 63'd1);
      send_word(63'd97, 63'd96);
      send_word(63'd97, 63'h7FFF_FFFF_FFFF_FFFF);
      send_word(63'd91, 63'd90);
   endtask

   task automatic test_known_numbers();
      send_word(63'd2047, 63'd2);
      send_word(63'd561, 63'd2);
      send_word(63'd561, 63'd7);
      send_word(63'h1FFF_FFFF_FFFF_FFFF, 63'd2);
      send_word(63'h1FFF_FFFF_FFFF_FFFF, 63'h5555_5555_5555_5555);
      send_word(63'h7FFF_FFFF_FFFF_FFFF, 63'd2);
      send_word(63'h7FFF_FFFF_FFFF_FFE7, 63'h2AAA_AAAA_AAAA_AAAA);
      send_word(63'h4000_0000_0000_0001, 63'd3);
      wait_drained();
   endtask

   task automatic test_random_words();
      bit [WordBits-1:0] cand, base;
      int pick;
      for (int k = 0; k < 100; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // Small odd candidates keep most rounds short.
            cand = WordBits'($urandom_range(5, 65535) | 1);
            base = WordBits'($urandom_range(2, int'(cand) - 2));
         end else if (pick < 75) begin
            cand = rand_word() | 1;
            base = rand_word();
         end else if (pick < 85) begin
            cand = rand_word() & ~63'd1;
            base = rand_word();
         end else begin
            cand = (pick[0]) ? 63'h7FFF_FFFF_FFFF_FFE7 : 63'h1FFF_FFFF_FFFF_FFFF;
            base = rand_word();
         end
         send_word(cand, base);
         if (k == 50) wait_drained();
      end
   endtask

   // Result check, receiver stall pattern and watchdog.
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[11:10])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_ready <= (stall_cycle % 7) != 0;
         default: rsp_ready <= stall_cycle[3];
      endcase
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict with no word outstanding: actual %0d", rsp_verdict);
               errors++;
            end else begin
               if (rsp_verdict !== expected_verdicts[0]) begin
                  $error("verdict mismatch: expected %0d actual %0d",
                         expected_verdicts[0], rsp_verdict);
                  errors++;
               end
               void'(expected_verdicts.pop_front());
            end
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_trivial_cases();
      test_base_edges();
      test_known_numbers();
      test_random_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/mrw_pkg.sv
rtl/mrw_front.sv
rtl/mrw_back.sv
rtl/miller_rabin_witness_round_core.sv
test/miller_rabin_witness_round_core_tb.sv
